/* src/hsed_pkg.sv */
`timescale 1ns / 1ps

package hsed_pkg;

	localparam int CW_W   = 63;
	localparam int DATA_W = 57;
	localparam int SYN_W  = 6;
	localparam int LEN_W  = 6;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(7);

	typedef logic [CW_W-1:0]   codeword_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [SYN_W-1:0]  syn_t;
	typedef logic [LEN_W-1:0]  len_t;

	// Syndrome stage to correction stage
	typedef struct packed {
		codeword_t word;
		syn_t      syndrome;
		len_t      len;
	} check_t;

	// One decoded result
	typedef struct packed {
		data_t data_bits;
		syn_t  syndrome;
		logic  corrected;
		logic  out_of_range;
	} result_t;

	// Codeword bits that feed parity check j: positions with bit j set
	function automatic codeword_t syn_mask(input int j);
		codeword_t m;
		m = '0;
		for (int i = 0; i < CW_W; i++) begin
			m[i] = 1'(((i + 1) >> j) & 1);
		end
		return m;
	endfunction

	// Bit index in the codeword of the k-th data position (k from 0)
	function automatic int data_index(input int k);
		int cnt;
		int idx;
		cnt = 0;
		idx = 0;
		for (int pos = 1; pos <= CW_W; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				if (cnt == k) begin
					idx = pos - 1;
				end
				cnt++;
			end
		end
		return idx;
	endfunction

endpackage

/* src/hsed_syndrome.sv */
`timescale 1ns / 1ps

module hsed_syndrome import hsed_pkg::*; (
	input  codeword_t codeword,
	input  len_t      len,
	output check_t    check
);

	codeword_t word;

	// Drop bits beyond the code length
	assign word = codeword & ~({CW_W{1'b1}} << len);

	always_comb begin
		check.word = word;
		check.len  = len;
		for (int j = 0; j < SYN_W; j++) begin
			check.syndrome[j] = ^(word & syn_mask(j));
		end
	end

endmodule

/* src/hsed_correct.sv */
`timescale 1ns / 1ps

module hsed_correct import hsed_pkg::*; (
	input  check_t  check,
	output result_t result
);

	logic      nonzero;
	logic      oor;
	logic      fix;
	syn_t      flip_idx;
	codeword_t fixed_word;

	assign nonzero    = (check.syndrome != '0);
	assign oor        = nonzero && (check.syndrome > check.len);
	assign fix        = nonzero && !oor;
	assign flip_idx   = check.syndrome - SYN_W'(1);
	assign fixed_word = fix ? (check.word ^ (CW_W'(1) << flip_idx)) : check.word;

	always_comb begin
		result.syndrome     = check.syndrome;
		result.corrected    = fix;
		result.out_of_range = oor;
		// Gather the non-power-of-two positions in order
		for (int k = 0; k < DATA_W; k++) begin
			result.data_bits[k] = fixed_word[data_index(k)];
		end
	end

endmodule

/* src/hamming_single_error_decoder_core.sv */
`timescale 1ns / 1ps
// Hamming single-error-correcting decoder, parity at positions 1, 2, 4, ...
//
// Command channel: raise start with a codeword; the transfer happens at the
// clock edge where start is high and busy is low. busy stays low, so a new
// codeword may be offered in every cycle.
// Result channel: done is high for exactly one cycle with data_bits,
// syndrome, corrected and syndrome_out_of_range; the transfer happens at the
// edge that ends that cycle. The receiver cannot stall, so nothing is held.
// Path: a transfer loads the input register, the result register holds the
// decoded word for the ports. Throughput: one codeword per cycle, set by the
// input register and the result register around the XOR trees and gather.
// Configuration: code_length_we writes code_length_wdata into the length
// register; write it only while no decode is in flight. Lengths above
// MAX_CODE_BITS are clamped.
// Reset (arst_n low): length register returns to 7, pipeline empties, done
// drops low at once.

module hamming_single_error_decoder_core import hsed_pkg::*; #(
	parameter int MAX_CODE_BITS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CW_W-1:0]   codeword,
	input  logic              code_length_we,
	input  logic [LEN_W-1:0]  code_length_wdata,
	output logic              done,
	output logic [DATA_W-1:0] data_bits,
	output logic [SYN_W-1:0]  syndrome,
	output logic              corrected,
	output logic              syndrome_out_of_range
);

	localparam len_t MAX_LEN = LEN_W'(MAX_CODE_BITS);

	len_t      code_length_q;
	len_t      len_eff;
	logic      valid_s1;
	codeword_t codeword_s1;
	len_t      len_s1;
	check_t    check;
	result_t   result;
	logic      done_s2;
	result_t   result_s2;

	// Never back-pressure the sender
	assign busy = 1'b0;

	// Clamp the length to what the code supports
	assign len_eff = (code_length_q > MAX_LEN) ? MAX_LEN : code_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= LEN_RESET;
		end else if (code_length_we) begin
			code_length_q <= code_length_wdata;
		end
	end

	// Input register: control cleared on reset, payload loaded on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			codeword_s1 <= codeword;
			len_s1      <= len_eff;
		end
	end

	hsed_syndrome u_syndrome (
		.codeword (codeword_s1),
		.len      (len_s1),
		.check    (check)
	);

	hsed_correct u_correct (
		.check  (check),
		.result (result)
	);

	// Result register: strobe for one cycle per decoded word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= result;
		end
	end

	assign done                  = done_s2;
	assign data_bits             = result_s2.data_bits;
	assign syndrome              = result_s2.syndrome;
	assign corrected             = result_s2.corrected;
	assign syndrome_out_of_range = result_s2.out_of_range;

endmodule

/* tb/sv/hamming_decode_checker.sv */
`timescale 1ns / 1ps

module hamming_decode_checker import hsed_pkg::*; #(
	parameter int MAX_CODE_BITS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [CW_W-1:0]   codeword,
	input  logic              code_length_we,
	input  logic [LEN_W-1:0]  code_length_wdata,
	input  logic              done,
	input  logic [DATA_W-1:0] data_bits,
	input  logic [SYN_W-1:0]  syndrome,
	input  logic              corrected,
	input  logic              syndrome_out_of_range,
	output int                mismatches,
	output int                in_flight
);

	len_t    length_shadow;
	result_t decoded_q[$];

	// Expected decode of one codeword at the given length
	function automatic result_t decode_word(input codeword_t word, input len_t len);
		int      n;
		int      syn;
		int      k;
		logic    par;
		result_t r;
		n = int'(len);
		if (n > MAX_CODE_BITS) begin
			n = MAX_CODE_BITS;
		end
		r = '0;
		syn = 0;
		for (int p = 1; p <= n; p <<= 1) begin
			par = 1'b0;
			for (int pos = 1; pos <= n; pos++) begin
				if ((pos & p) != 0) begin
					par ^= word[pos - 1];
				end
			end
			if (par) begin
				syn |= p;
			end
		end
		if (syn != 0) begin
			if (syn > n) begin
				r.out_of_range = 1'b1;
			end else begin
				word[syn - 1] = ~word[syn - 1];
				r.corrected = 1'b1;
			end
		end
		k = 0;
		for (int pos = 1; pos <= n; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				r.data_bits[k] = word[pos - 1];
				k++;
			end
		end
		r.syndrome = syn_t'(syn);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			length_shadow = LEN_RESET;
			decoded_q.delete();
			in_flight = 0;
		end else begin
			if (done) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("unexpected result, data_bits", 64'(data_bits), 64'd0);
				end else begin
					want = decoded_q.pop_front();
					if (data_bits !== want.data_bits) begin
						report_mismatch("data_bits", 64'(data_bits), 64'(want.data_bits));
					end
					if (syndrome !== want.syndrome) begin
						report_mismatch("syndrome", 64'(syndrome), 64'(want.syndrome));
					end
					if (corrected !== want.corrected) begin
						report_mismatch("corrected", 64'(corrected), 64'(want.corrected));
					end
					if (syndrome_out_of_range !== want.out_of_range) begin
						report_mismatch("syndrome_out_of_range", 64'(syndrome_out_of_range),
							64'(want.out_of_range));
					end
				end
			end
			if (start && !busy) begin
				decoded_q.insert(decoded_q.size(), decode_word(codeword, length_shadow));
			end
			if (code_length_we) begin
				length_shadow = code_length_wdata;
			end
			in_flight = decoded_q.size();
		end
	end

endmodule

/* tb/sv/hamming_single_error_decoder_core_test.sv */
`timescale 1ns / 1ps

module hamming_single_error_decoder_core_test;
	import hsed_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PHASES   = 20;
	localparam int WORDS_PER_PHASE = 78;

	// How a random codeword is built
	typedef enum int {
		WORD_CLEAN,
		WORD_ONE_FLIP,
		WORD_NOISE
	} word_kind_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CW_W-1:0]   codeword;
	logic              code_length_we;
	logic [LEN_W-1:0]  code_length_wdata;
	logic              done;
	logic [DATA_W-1:0] data_bits;
	logic [SYN_W-1:0]  syndrome;
	logic              corrected;
	logic              syndrome_out_of_range;

	int   mismatches;
	int   in_flight;
	int   cycle_count = 0;
	bit   no_idle;
	len_t length_now;

	// Lengths swept first: the degenerate short ones, the full code and the
	// edges around each power of two, where out-of-range syndromes appear
	len_t sweep_lengths [16] = '{
		6'd63, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6,
		6'd7, 6'd8, 6'd15, 6'd16, 6'd31, 6'd32, 6'd33, 6'd62
	};

	hamming_single_error_decoder_core u_top (
		.clk                   (clk),
		.arst_n                (arst_n),
		.start                 (start),
		.busy                  (busy),
		.codeword              (codeword),
		.code_length_we        (code_length_we),
		.code_length_wdata     (code_length_wdata),
		.done                  (done),
		.data_bits             (data_bits),
		.syndrome              (syndrome),
		.corrected             (corrected),
		.syndrome_out_of_range (syndrome_out_of_range)
	);

	hamming_decode_checker u_checker (
		.clk                   (clk),
		.arst_n                (arst_n),
		.start                 (start),
		.busy                  (busy),
		.codeword              (codeword),
		.code_length_we        (code_length_we),
		.code_length_wdata     (code_length_wdata),
		.done                  (done),
		.data_bits             (data_bits),
		.syndrome              (syndrome),
		.corrected             (corrected),
		.syndrome_out_of_range (syndrome_out_of_range),
		.mismatches            (mismatches),
		.in_flight             (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL hamming_single_error_decoder_core");
			$finish;
		end
	end

	// Fill in the parity positions within length n so that every check passes.
	// A parity position sits in its own group only, so each group is settled
	// independently of the others.
	function automatic codeword_t seal_codeword(input codeword_t word, input int n);
		logic par;
		for (int p = 1; p <= n; p <<= 1) begin
			word[p - 1] = 1'b0;
			par = 1'b0;
			for (int pos = 1; pos <= n; pos++) begin
				if ((pos & p) != 0) begin
					par ^= word[pos - 1];
				end
			end
			word[p - 1] = par;
		end
		return word;
	endfunction

	// Random content everywhere, including the ignored bits above the length
	function automatic codeword_t make_word(input word_kind_t kind, input int n);
		codeword_t word;
		word = codeword_t'({$urandom, $urandom});
		if (kind != WORD_NOISE) begin
			word = seal_codeword(word, n);
		end
		if (kind == WORD_ONE_FLIP && n > 0) begin
			word[$urandom_range(n - 1, 0)] ^= 1'b1;
		end
		return word;
	endfunction

	// Mostly proper codewords, clean or with one hit; the rest raw noise,
	// which brings multi-bit errors and out-of-range syndromes
	function automatic word_kind_t pick_kind();
		int r;
		r = $urandom_range(99, 0);
		if (r < 35) begin
			return WORD_CLEAN;
		end
		if (r < 75) begin
			return WORD_ONE_FLIP;
		end
		return WORD_NOISE;
	endfunction

	// Gap after a transfer: mostly none or short, now and then a long one
	function automatic int idle_cycles();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(30, 8);
	endfunction

	// Offer one codeword and hold it until the transfer; return on a falling
	// edge with no pending assignment to start in that step
	task automatic send_word(input codeword_t word);
		int gap;
		start <= 1'b1;
		codeword <= word;
		do @(posedge clk); while (busy);
		@(negedge clk);
		gap = idle_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			// drive junk while idle: it must not be taken
			codeword <= codeword_t'({$urandom, $urandom});
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop start, drain the pipeline, then write the length register
	task automatic set_length(input len_t value);
		start <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		code_length_we <= 1'b1;
		code_length_wdata <= value;
		@(negedge clk);
		code_length_we <= 1'b0;
		length_now = value;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		codeword = '0;
		code_length_we = 1'b0;
		code_length_wdata = '0;
		no_idle = 1'b0;
		length_now = LEN_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset length of 7: clean all-zero and all-one
		// codewords, an error at every position, and junk above the length
		send_word('0);
		send_word('1);
		for (int pos = 0; pos < 7; pos++) begin
			send_word(codeword_t'(1) << pos);
		end
		send_word({{56{1'b1}}, 7'b0});

		// Full length: clean extremes, hits on the first, middle and last bit
		set_length(6'd63);
		send_word('0);
		send_word('1);
		send_word(codeword_t'(1));
		send_word(codeword_t'(1) << 62);
		send_word(codeword_t'(1) << 31);
		send_word(63'h2AAA_AAAA_AAAA_AAAA);

		// Zero length: nothing in use, so no syndrome and no data
		set_length(6'd0);
		send_word('1);
		// Length 2: syndrome 3 points past the end of the word
		set_length(6'd2);
		send_word(63'h3);
		// Length 6: syndrome 7 is out of range, the word passes through
		set_length(6'd6);
		send_word(63'hB);

		// Random phases: swept lengths first, then random ones; some phases
		// run back to back with no idle cycles at all
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 16) begin
				set_length(sweep_lengths[ph]);
			end else begin
				set_length(len_t'($urandom_range(63, 0)));
			end
			no_idle = ($urandom_range(3, 0) == 0);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				send_word(make_word(pick_kind(), int'(length_now)));
			end
		end

		// Drain, then allow a few cycles for any stray strobe to show up
		start <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS hamming_single_error_decoder_core");
		end else begin
			$display("FAIL hamming_single_error_decoder_core");
		end
		$finish;
	end

endmodule
